FILE: hdl/izh_pkg.sv
// izh_pkg: shared types, constants, microcode format and microcode ROM for the
// Izhikevich neuron step block. Used by izh_seq, izh_dp and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package izh_pkg;

    // widths
    localparam int QW        = 32;
    localparam int TW        = 31;
    localparam int ACC_W     = 40;
    localparam int PS_W      = 48;
    localparam int PROD_W    = 64;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 3;

    // Q16.16 constants
    localparam logic signed [QW-1:0] Q_K004    = 32'sd2621;
    localparam logic signed [QW-1:0] Q_K5      = 32'sd327680;
    localparam logic signed [QW-1:0] Q_140     = 32'sd9175040;
    localparam logic signed [QW-1:0] Q_30      = 32'sd1966080;
    localparam logic signed [QW-1:0] Q_RESET_V = -32'sd4259840;
    localparam logic signed [QW-1:0] Q_RESET_U = -32'sd851968;

    // register reset values
    localparam logic signed [QW-1:0] RST_RATE  = 32'sd1311;
    localparam logic signed [QW-1:0] RST_SENS  = 32'sd13107;
    localparam logic signed [QW-1:0] RST_RST_V = -32'sd4259840;
    localparam logic signed [QW-1:0] RST_JUMP  = 32'sd524288;
    localparam logic [TW-1:0]        RST_DT    = 31'd6554;
    localparam logic [TW-1:0]        RST_RDT   = 31'd20724;
    localparam logic signed [QW-1:0] RST_DRIVE = 32'sd655360;

    // saturation bounds on the shifted product width
    localparam logic signed [PS_W-1:0] SAT_HI = {{(PS_W-QW){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [PS_W-1:0] SAT_LO = {{(PS_W-QW){1'b1}}, 32'h8000_0000};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE  = 3'd0,
        CFG_SENS  = 3'd1,
        CFG_RST_V = 3'd2,
        CFG_JUMP  = 3'd3,
        CFG_DT    = 3'd4,
        CFG_RDT   = 3'd5,
        CFG_DRIVE = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [QW-1:0] rate;
        logic signed [QW-1:0] sens;
        logic signed [QW-1:0] rst_v;
        logic signed [QW-1:0] jump;
        logic [TW-1:0]        dt;
        logic [TW-1:0]        rdt;
        logic signed [QW-1:0] drive;
    } cfg_t;

    // microcode field codes
    typedef enum logic [2:0] {
        MA_NOISE = 3'd0,
        MA_V     = 3'd1,
        MA_K004  = 3'd2,
        MA_SENS  = 3'd3,
        MA_SACC  = 3'd4,
        MA_SP    = 3'd5
    } mul_a_sel_t;

    typedef enum logic [2:0] {
        MB_RDT  = 3'd0,
        MB_V    = 3'd1,
        MB_SP   = 3'd2,
        MB_K5   = 3'd3,
        MB_DT   = 3'd4,
        MB_RATE = 3'd5
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        ACC_NOP  = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef enum logic [3:0] {
        AS_DRIVE = 4'd0,
        AS_NOISE = 4'd1,
        AS_C140  = 4'd2,
        AS_PS    = 4'd3,
        AS_U     = 4'd4,
        AS_SP    = 4'd5,
        AS_T0    = 4'd6,
        AS_V     = 4'd7,
        AS_T1    = 4'd8,
        AS_NT    = 4'd9,
        AS_JUMP  = 4'd10
    } acc_src_t;

    typedef enum logic [2:0] {
        WD_NONE = 3'd0,
        WD_V    = 3'd1,
        WD_U    = 3'd2,
        WD_NT   = 3'd3,
        WD_TOT  = 3'd4,
        WD_T0   = 3'd5,
        WD_T1   = 3'd6
    } wb_dst_t;

    typedef enum logic [2:0] {
        WS_SATP    = 3'd0,
        WS_SACC    = 3'd1,
        WS_RST_V   = 3'd2,
        WS_START_V = 3'd3,
        WS_START_U = 3'd4,
        WS_ZERO    = 3'd5,
        WS_DRIVE   = 3'd6
    } wb_src_t;

    typedef enum logic [1:0] {
        SEQ_NEXT     = 2'd0,
        SEQ_END      = 2'd1,
        SEQ_END_LT30 = 2'd2
    } seq_op_t;

    // one control word
    typedef struct packed {
        logic       mul_en;
        mul_a_sel_t mul_a;
        mul_b_sel_t mul_b;
        acc_op_t    acc_op;
        acc_src_t   acc_src;
        wb_dst_t    wb_dst;
        wb_src_t    wb_src;
        logic       set_spike;
        seq_op_t    seq_op;
    } ucw_t;

    localparam ucw_t UCW_NOP = '{
        mul_en:    1'b0,
        mul_a:     MA_V,
        mul_b:     MB_V,
        acc_op:    ACC_NOP,
        acc_src:   AS_DRIVE,
        wb_dst:    WD_NONE,
        wb_src:    WS_SATP,
        set_spike: 1'b0,
        seq_op:    SEQ_NEXT
    };

    // program entry points
    localparam logic [STEP_W-1:0] TICK_ENTRY    = 5'd0;
    localparam logic [STEP_W-1:0] RESTART_ENTRY = 5'd18;

    // top to sequencer, sequencer to top and datapath to sequencer
    typedef struct packed {
        logic start;
        logic restart;
        logic out_ok;
    } seq_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    typedef struct packed {
        logic v_ge30;
    } dp_stat_t;

    // saturate a shifted product or sum to 32-bit signed
    function automatic logic signed [QW-1:0] sat32(input logic signed [PS_W-1:0] x);
        logic signed [QW-1:0] r;
        if (x > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[QW-1:0];
        end
        return r;
    endfunction

    // microcode ROM: tick program at TICK_ENTRY, restart program at RESTART_ENTRY
    function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucw_t w;
        w = UCW_NOP;
        unique case (addr)
            // noise * sqrt(dt); acc = I
            5'd0: begin
                w.mul_en = 1'b1; w.mul_a = MA_NOISE; w.mul_b = MB_RDT;
                w.acc_op = ACC_LOAD; w.acc_src = AS_DRIVE;
            end
            // noise term out; v*v; acc = I + noise
            5'd1: begin
                w.wb_dst = WD_NT; w.wb_src = WS_SATP;
                w.mul_en = 1'b1; w.mul_a = MA_V; w.mul_b = MB_V;
                w.acc_op = ACC_ADD; w.acc_src = AS_NOISE;
            end
            // total current out; 0.04 * v^2; bracket starts at 140
            5'd2: begin
                w.wb_dst = WD_TOT; w.wb_src = WS_SACC;
                w.mul_en = 1'b1; w.mul_a = MA_K004; w.mul_b = MB_SP;
                w.acc_op = ACC_LOAD; w.acc_src = AS_C140;
            end
            // 5v; add 0.04 v^2
            5'd3: begin
                w.mul_en = 1'b1; w.mul_a = MA_V; w.mul_b = MB_K5;
                w.acc_op = ACC_ADD; w.acc_src = AS_PS;
            end
            // b*v; add 5v
            5'd4: begin
                w.mul_en = 1'b1; w.mul_a = MA_SENS; w.mul_b = MB_V;
                w.acc_op = ACC_ADD; w.acc_src = AS_PS;
            end
            // keep b*v; subtract u
            5'd5: begin
                w.wb_dst = WD_T0; w.wb_src = WS_SATP;
                w.acc_op = ACC_SUB; w.acc_src = AS_U;
            end
            // add I
            5'd6: begin
                w.acc_op = ACC_ADD; w.acc_src = AS_DRIVE;
            end
            // bracket * dt; acc = b*v
            5'd7: begin
                w.mul_en = 1'b1; w.mul_a = MA_SACC; w.mul_b = MB_DT;
                w.acc_op = ACC_LOAD; w.acc_src = AS_T0;
            end
            // keep dv; acc = b*v - u
            5'd8: begin
                w.wb_dst = WD_T1; w.wb_src = WS_SATP;
                w.acc_op = ACC_SUB; w.acc_src = AS_U;
            end
            // a * diff; acc = v
            5'd9: begin
                w.mul_en = 1'b1; w.mul_a = MA_SACC; w.mul_b = MB_RATE;
                w.acc_op = ACC_LOAD; w.acc_src = AS_V;
            end
            // (a*diff) * dt; add dv
            5'd10: begin
                w.mul_en = 1'b1; w.mul_a = MA_SP; w.mul_b = MB_DT;
                w.acc_op = ACC_ADD; w.acc_src = AS_T1;
            end
            // add noise term
            5'd11: begin
                w.acc_op = ACC_ADD; w.acc_src = AS_NT;
            end
            // new v; acc = u
            5'd12: begin
                w.wb_dst = WD_V; w.wb_src = WS_SACC;
                w.acc_op = ACC_LOAD; w.acc_src = AS_U;
            end
            // add du
            5'd13: begin
                w.acc_op = ACC_ADD; w.acc_src = AS_SP;
            end
            // new u; done unless threshold reached
            5'd14: begin
                w.wb_dst = WD_U; w.wb_src = WS_SACC;
                w.seq_op = SEQ_END_LT30;
            end
            // spike: v = c; acc = u
            5'd15: begin
                w.wb_dst = WD_V; w.wb_src = WS_RST_V;
                w.acc_op = ACC_LOAD; w.acc_src = AS_U;
            end
            // add d
            5'd16: begin
                w.acc_op = ACC_ADD; w.acc_src = AS_JUMP;
            end
            // u = u + d, flag spike
            5'd17: begin
                w.wb_dst = WD_U; w.wb_src = WS_SACC;
                w.set_spike = 1'b1; w.seq_op = SEQ_END;
            end
            // restart: load v
            5'd18: begin
                w.wb_dst = WD_V; w.wb_src = WS_START_V;
            end
            // load u
            5'd19: begin
                w.wb_dst = WD_U; w.wb_src = WS_START_U;
            end
            // noise term is zero
            5'd20: begin
                w.wb_dst = WD_NT; w.wb_src = WS_ZERO;
            end
            // total current is the drive alone
            5'd21: begin
                w.wb_dst = WD_TOT; w.wb_src = WS_DRIVE;
                w.seq_op = SEQ_END;
            end
            default: begin
                w.seq_op = SEQ_END;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/izhikevich_neuron_step_top.sv
// izhikevich_neuron_step_top: top level with handshakes, configuration
// registers, step counter and output register. Depends on izh_pkg, izh_seq, izh_dp.
`timescale 1ns / 1ps
`default_nettype none

// One Izhikevich neuron in signed Q16.16, advanced by one Euler-Maruyama step per
// tick beat (req_type 0) or reloaded by a restart beat (req_type 1). Each beat
// gives one result beat. A microcoded sequencer steps a single 32x32 multiplier
// and a 40-bit accumulator, one control word per cycle: a tick runs 15 steps, 18
// when the neuron fires, and a restart runs 4; the done state then hands the
// result to the output register once that register is free or being taken. The
// next beat is accepted as soon as the result sits in the output register, even
// if it is not yet taken. Configuration writes are taken every cycle and must
// only happen while idle.
module izhikevich_neuron_step_top
    import izh_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // configuration write channel
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [QW-1:0]            cfg_data,
    // input channel
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_req_type,
    input  wire logic signed [QW-1:0]     s_noise_sample,
    input  wire logic signed [QW-1:0]     s_start_potential,
    input  wire logic signed [QW-1:0]     s_start_recovery,
    // result channel
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [QW-1:0]          m_potential_out,
    output logic signed [QW-1:0]          m_recovery_out,
    output logic                          m_spiked,
    output logic [QW-1:0]                 m_step_number,
    output logic signed [QW-1:0]          m_noise_term,
    output logic signed [QW-1:0]          m_total_current
);

    cfg_t       cfg_reg;
    seq_cmd_t   seq_cmd;
    seq_stat_t  seq_stat;
    dp_stat_t   dp_stat;
    ucw_t       ctrl;

    logic                 in_beat;
    logic [QW-1:0]        step_count_reg;
    logic                 restart_reg;
    logic                 m_valid_reg;
    logic signed [QW-1:0] pot_reg, rec_reg, nt_reg, tot_reg;
    logic                 spiked_reg;
    logic [QW-1:0]        step_num_reg;

    logic signed [QW-1:0] dp_v, dp_u, dp_nt, dp_tot;
    logic                 dp_spike;

    assign cfg_ready = 1'b1;
    assign s_ready   = seq_stat.idle;
    assign in_beat   = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate  <= RST_RATE;
            cfg_reg.sens  <= RST_SENS;
            cfg_reg.rst_v <= RST_RST_V;
            cfg_reg.jump  <= RST_JUMP;
            cfg_reg.dt    <= RST_DT;
            cfg_reg.rdt   <= RST_RDT;
            cfg_reg.drive <= RST_DRIVE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RATE:  cfg_reg.rate  <= cfg_data;
                CFG_SENS:  cfg_reg.sens  <= cfg_data;
                CFG_RST_V: cfg_reg.rst_v <= cfg_data;
                CFG_JUMP:  cfg_reg.jump  <= cfg_data;
                CFG_DT:    cfg_reg.dt    <= cfg_data[TW-1:0];
                CFG_RDT:   cfg_reg.rdt   <= cfg_data[TW-1:0];
                CFG_DRIVE: cfg_reg.drive <= cfg_data;
                default:   ;
            endcase
        end
    end

    // step counter, cleared by restart
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= '0;
            restart_reg    <= 1'b0;
        end else if (in_beat) begin
            restart_reg    <= s_req_type;
            step_count_reg <= s_req_type ? '0 : step_count_reg + 1'b1;
        end
    end

    // sequencer and datapath
    assign seq_cmd.start   = in_beat;
    assign seq_cmd.restart = s_req_type;
    assign seq_cmd.out_ok  = !m_valid_reg || m_ready;

    izh_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (seq_cmd),
        .dp_stat (dp_stat),
        .ctrl    (ctrl),
        .stat    (seq_stat)
    );

    izh_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .ctrl       (ctrl),
        .in_load    (in_beat),
        .in_noise   (s_noise_sample),
        .in_start_v (s_start_potential),
        .in_start_u (s_start_recovery),
        .v_out      (dp_v),
        .u_out      (dp_u),
        .nt_out     (dp_nt),
        .tot_out    (dp_tot),
        .spike_out  (dp_spike),
        .stat       (dp_stat)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_stat.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_stat.done) begin
            pot_reg      <= dp_v;
            rec_reg      <= dp_u;
            spiked_reg   <= dp_spike;
            step_num_reg <= step_count_reg;
            nt_reg       <= dp_nt;
            tot_reg      <= dp_tot;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_potential_out = pot_reg;
    assign m_recovery_out  = rec_reg;
    assign m_spiked        = spiked_reg;
    assign m_step_number   = step_num_reg;
    assign m_noise_term    = nt_reg;
    assign m_total_current = tot_reg;

`ifndef SYNTHESIS
    // no new beat is taken while a step is in flight
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input beat accepted while sequencer busy");

    // a result is only handed over when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_stat.done |-> (!m_valid_reg || m_ready))
        else $error("result would overwrite a pending output beat");

    // restart result carries step zero, no spike and no noise
    a_restart_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_stat.done && restart_reg) |=>
            ((m_step_number == '0) && !m_spiked && (m_noise_term == '0)))
        else $error("restart result fields wrong");

    // a spike leaves the potential at the reset potential
    a_spike_potential: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_stat.done |=> (!m_spiked || (m_potential_out == $past(cfg_reg.rst_v))))
        else $error("spike without potential reset");
`endif

endmodule

`default_nettype wire

FILE: hdl/izh_seq.sv
// izh_seq: microcode sequencer with step counter, ROM lookup and end-of-program
// branch on the spike threshold. Depends on izh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module izh_seq
    import izh_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire seq_cmd_t  cmd,
    input  wire dp_stat_t  dp_stat,
    output ucw_t           ctrl,
    output seq_stat_t      stat
);

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_RUN  = 3'b010,
        SQ_DONE = 3'b100
    } sq_state_t;

    sq_state_t          state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    ucw_t               rom_word;
    logic               finish;

    // control word fetch
    assign rom_word = ucode_rom(step_reg);
    assign ctrl     = (state_reg == SQ_RUN) ? rom_word : UCW_NOP;

    // end of program, unconditional or conditional on the threshold
    always_comb begin
        case (rom_word.seq_op)
            SEQ_END:      finish = 1'b1;
            SEQ_END_LT30: finish = !dp_stat.v_ge30;
            default:      finish = 1'b0;
        endcase
    end

    // step counter and run control
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            SQ_IDLE: begin
                if (cmd.start) begin
                    state_next = SQ_RUN;
                    step_next  = cmd.restart ? RESTART_ENTRY : TICK_ENTRY;
                end
            end
            SQ_RUN: begin
                if (finish) begin
                    state_next = SQ_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            SQ_DONE: begin
                if (cmd.out_ok) begin
                    state_next = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            step_reg  <= TICK_ENTRY;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // status to the top level
    assign stat.idle = (state_reg == SQ_IDLE);
    assign stat.done = (state_reg == SQ_DONE) && cmd.out_ok;

endmodule

`default_nettype wire

FILE: hdl/izh_dp.sv
// izh_dp: datapath driven by the microcode word: one 32x32 multiplier with a
// registered product, a 40-bit accumulator and the neuron state registers.
// Depends on izh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module izh_dp
    import izh_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire ucw_t                 ctrl,
    input  wire logic                 in_load,
    input  wire logic signed [QW-1:0] in_noise,
    input  wire logic signed [QW-1:0] in_start_v,
    input  wire logic signed [QW-1:0] in_start_u,
    output logic signed [QW-1:0]      v_out,
    output logic signed [QW-1:0]      u_out,
    output logic signed [QW-1:0]      nt_out,
    output logic signed [QW-1:0]      tot_out,
    output logic                      spike_out,
    output dp_stat_t                  stat
);

    logic signed [QW-1:0]     v_reg, u_reg, nt_reg, tot_reg, t0_reg, t1_reg;
    logic signed [QW-1:0]     noise_reg, start_v_reg, start_u_reg;
    logic                     spike_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [PS_W-1:0]   ps;
    logic signed [QW-1:0]     sp, sacc;
    logic signed [QW-1:0]     mul_a, mul_b;
    logic signed [QW-1:0]     dt_s, rdt_s;
    logic signed [ACC_W-1:0]  acc_opnd;
    logic signed [QW-1:0]     wb_val;

    // product shifted down by 16 (floor) and saturated forms
    assign ps    = $signed(prod_reg[PROD_W-1:16]);
    assign sp    = sat32(ps);
    assign sacc  = sat32($signed({{(PS_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg}));
    assign dt_s  = $signed({1'b0, cfg.dt});
    assign rdt_s = $signed({1'b0, cfg.rdt});

    // multiplier operand select
    always_comb begin
        unique case (ctrl.mul_a)
            MA_NOISE: mul_a = noise_reg;
            MA_V:     mul_a = v_reg;
            MA_K004:  mul_a = Q_K004;
            MA_SENS:  mul_a = cfg.sens;
            MA_SACC:  mul_a = sacc;
            MA_SP:    mul_a = sp;
            default:  mul_a = v_reg;
        endcase
        unique case (ctrl.mul_b)
            MB_RDT:  mul_b = rdt_s;
            MB_V:    mul_b = v_reg;
            MB_SP:   mul_b = sp;
            MB_K5:   mul_b = Q_K5;
            MB_DT:   mul_b = dt_s;
            MB_RATE: mul_b = cfg.rate;
            default: mul_b = v_reg;
        endcase
    end

    // accumulator operand select
    always_comb begin
        unique case (ctrl.acc_src)
            AS_DRIVE: acc_opnd = ACC_W'(cfg.drive);
            AS_NOISE: acc_opnd = ACC_W'(noise_reg);
            AS_C140:  acc_opnd = ACC_W'(Q_140);
            AS_PS:    acc_opnd = ps[ACC_W-1:0];
            AS_U:     acc_opnd = ACC_W'(u_reg);
            AS_SP:    acc_opnd = ACC_W'(sp);
            AS_T0:    acc_opnd = ACC_W'(t0_reg);
            AS_V:     acc_opnd = ACC_W'(v_reg);
            AS_T1:    acc_opnd = ACC_W'(t1_reg);
            AS_NT:    acc_opnd = ACC_W'(nt_reg);
            AS_JUMP:  acc_opnd = ACC_W'(cfg.jump);
            default:  acc_opnd = '0;
        endcase
    end

    // write-back value select
    always_comb begin
        unique case (ctrl.wb_src)
            WS_SATP:    wb_val = sp;
            WS_SACC:    wb_val = sacc;
            WS_RST_V:   wb_val = cfg.rst_v;
            WS_START_V: wb_val = start_v_reg;
            WS_START_U: wb_val = start_u_reg;
            WS_ZERO:    wb_val = '0;
            WS_DRIVE:   wb_val = cfg.drive;
            default:    wb_val = '0;
        endcase
    end

    // multiplier, accumulator, temporaries and latched input beat
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        case (ctrl.acc_op)
            ACC_LOAD: acc_reg <= acc_opnd;
            ACC_ADD:  acc_reg <= acc_reg + acc_opnd;
            ACC_SUB:  acc_reg <= acc_reg - acc_opnd;
            default:  acc_reg <= acc_reg;
        endcase
        case (ctrl.wb_dst)
            WD_NT:   nt_reg  <= wb_val;
            WD_TOT:  tot_reg <= wb_val;
            WD_T0:   t0_reg  <= wb_val;
            WD_T1:   t1_reg  <= wb_val;
            default: ;
        endcase
        if (in_load) begin
            noise_reg   <= in_noise;
            start_v_reg <= in_start_v;
            start_u_reg <= in_start_u;
            spike_reg   <= 1'b0;
        end else if (ctrl.set_spike) begin
            spike_reg <= 1'b1;
        end
    end

    // neuron state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= Q_RESET_V;
            u_reg <= Q_RESET_U;
        end else begin
            if (ctrl.wb_dst == WD_V) begin
                v_reg <= wb_val;
            end
            if (ctrl.wb_dst == WD_U) begin
                u_reg <= wb_val;
            end
        end
    end

    assign v_out       = v_reg;
    assign u_out       = u_reg;
    assign nt_out      = nt_reg;
    assign tot_out     = tot_reg;
    assign spike_out   = spike_reg;
    assign stat.v_ge30 = (v_reg >= Q_30);

endmodule

`default_nettype wire

FILE: verif/izh_tb_pkg.sv
// izh_tb_pkg: request codes and the spare register index shared by the
// testbench top and the checker. Depends on izh_pkg for the index width.
`timescale 1ns / 1ps

package izh_tb_pkg;

    import izh_pkg::*;

    // request kinds carried by s_req_type
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // index past the end of the register list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

endpackage

FILE: verif/izh_step_checker.sv
// izh_step_checker: watches the config, input and result channels of the neuron
// step block, predicts each result beat and compares it field by field.
// Depends on izh_pkg and izh_tb_pkg.
`timescale 1ns / 1ps

module izh_step_checker
    import izh_pkg::*;
    import izh_tb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [QW-1:0]         cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_req_type,
    input  logic signed [QW-1:0]  s_noise_sample,
    input  logic signed [QW-1:0]  s_start_potential,
    input  logic signed [QW-1:0]  s_start_recovery,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic signed [QW-1:0]  m_potential_out,
    input  logic signed [QW-1:0]  m_recovery_out,
    input  logic                  m_spiked,
    input  logic [QW-1:0]         m_step_number,
    input  logic signed [QW-1:0]  m_noise_term,
    input  logic signed [QW-1:0]  m_total_current,
    output int                    fail_count,
    output int                    pending,
    output int                    results_checked,
    output int                    spikes_seen
);

    // fixed-point constants of the neuron equations
    localparam longint K_004      = 2621;
    localparam longint K_140      = 9175040;
    localparam longint V_PEAK     = 1966080;
    localparam longint Q_MAX      = 64'sh7FFF_FFFF;
    localparam longint Q_MIN      = -64'sh8000_0000;

    // register and state values after reset
    localparam logic signed [QW-1:0] RATE_AT_RESET  = 32'sd1311;
    localparam logic signed [QW-1:0] SENS_AT_RESET  = 32'sd13107;
    localparam logic signed [QW-1:0] C_AT_RESET     = -32'sd4259840;
    localparam logic signed [QW-1:0] JUMP_AT_RESET  = 32'sd524288;
    localparam logic [TW-1:0]        DT_AT_RESET    = 31'd6554;
    localparam logic [TW-1:0]        RDT_AT_RESET   = 31'd20724;
    localparam logic signed [QW-1:0] DRIVE_AT_RESET = 32'sd655360;
    localparam logic signed [QW-1:0] V_AT_RESET     = -32'sd4259840;
    localparam logic signed [QW-1:0] U_AT_RESET     = -32'sd851968;

    typedef struct {
        logic signed [QW-1:0] potential;
        logic signed [QW-1:0] recovery;
        logic                 spiked;
        logic [QW-1:0]        step;
        logic signed [QW-1:0] noise_term;
        logic signed [QW-1:0] total;
    } neuron_result_t;

    // neuron parameters as the block should hold them
    logic signed [QW-1:0] a_rate;
    logic signed [QW-1:0] b_sens;
    logic signed [QW-1:0] c_reset;
    logic signed [QW-1:0] d_jump;
    logic [TW-1:0]        dt_q;
    logic [TW-1:0]        rdt_q;
    logic signed [QW-1:0] i_drive;

    // neuron state
    logic signed [QW-1:0] v_now;
    logic signed [QW-1:0] u_now;
    logic [QW-1:0]        step_now;

    neuron_result_t expected_q[$];

    function automatic logic signed [QW-1:0] q_sat(input longint x);
        if (x > Q_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (x < Q_MIN) begin
            return 32'sh8000_0000;
        end
        return x[QW-1:0];
    endfunction

    // exact product, floor of the shift by 16, then saturate
    function automatic longint q_mul(input longint x, input longint y);
        return longint'(q_sat((x * y) >>> 16));
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [QW-1:0] data);
        case (cfg_idx_t'(idx))
            CFG_RATE:  a_rate  = data;
            CFG_SENS:  b_sens  = data;
            CFG_RST_V: c_reset = data;
            CFG_JUMP:  d_jump  = data;
            CFG_DT:    dt_q    = data[TW-1:0];
            CFG_RDT:   rdt_q   = data[TW-1:0];
            CFG_DRIVE: i_drive = data;
            default: ;
        endcase
    endfunction

    // one euler-maruyama step or a restart, updates the state
    function automatic neuron_result_t advance_neuron(input logic req,
                                                      input logic signed [QW-1:0] noise,
                                                      input logic signed [QW-1:0] v_start,
                                                      input logic signed [QW-1:0] u_start);
        neuron_result_t r;
        longint v, u, nz, nt, vsq, brk, dv, diff, du;
        r.spiked     = 1'b0;
        r.noise_term = '0;
        r.total      = i_drive;
        if (req == REQ_RESTART) begin
            v_now    = v_start;
            u_now    = u_start;
            step_now = '0;
        end else begin
            v  = longint'(v_now);
            u  = longint'(u_now);
            nz = longint'(noise);
            step_now     = step_now + 1;
            nt           = q_mul(nz, longint'(rdt_q));
            r.noise_term = nt[QW-1:0];
            r.total      = q_sat(longint'(i_drive) + nz);
            // potential: bracket summed exactly, saturated once before dt
            vsq   = q_mul(v, v);
            brk   = ((K_004 * vsq) >>> 16) + 5 * v + K_140 - u + longint'(i_drive);
            dv    = q_mul(longint'(q_sat(brk)), longint'(dt_q));
            v_now = q_sat(v + dv + nt);
            // recovery uses the potential from before the step
            diff  = longint'(q_sat(q_mul(longint'(b_sens), v) - u));
            du    = q_mul(q_mul(longint'(a_rate), diff), longint'(dt_q));
            u_now = q_sat(u + du);
            if (longint'(v_now) >= V_PEAK) begin
                v_now    = c_reset;
                u_now    = q_sat(longint'(u_now) + longint'(d_jump));
                r.spiked = 1'b1;
            end
        end
        r.potential = v_now;
        r.recovery  = u_now;
        r.step      = step_now;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [QW-1:0] want,
                                        input logic [QW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    // result beat first: it always belongs to an earlier input beat
    always @(posedge aclk) begin
        neuron_result_t want;
        neuron_result_t fresh;
        if (!aresetn) begin
            a_rate   = RATE_AT_RESET;
            b_sens   = SENS_AT_RESET;
            c_reset  = C_AT_RESET;
            d_jump   = JUMP_AT_RESET;
            dt_q     = DT_AT_RESET;
            rdt_q    = RDT_AT_RESET;
            i_drive  = DRIVE_AT_RESET;
            v_now    = V_AT_RESET;
            u_now    = U_AT_RESET;
            step_now = '0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("potential_out", want.potential, m_potential_out);
                    check_field("recovery_out", want.recovery, m_recovery_out);
                    check_field("spiked", {31'd0, want.spiked}, {31'd0, m_spiked});
                    check_field("step_number", want.step, m_step_number);
                    check_field("noise_term", want.noise_term, m_noise_term);
                    check_field("total_current", want.total, m_total_current);
                    results_checked++;
                    if (m_spiked) begin
                        spikes_seen++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                write_register(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                fresh = advance_neuron(s_req_type, s_noise_sample,
                                       s_start_potential, s_start_recovery);
                expected_q = {expected_q, fresh};
            end
        end
        pending = expected_q.size();
    end

endmodule

FILE: verif/tb.sv
// tb: stimulus and verdict for izhikevich_neuron_step_top; directed corner beats,
// then random segments under several register settings and flow-control regimes.
// Depends on izh_pkg, izh_tb_pkg and izh_step_checker.
`timescale 1ns / 1ps

module tb;

    import izh_pkg::*;
    import izh_tb_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [QW-1:0]        cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = REQ_TICK;
    logic signed [QW-1:0] s_noise_sample = '0;
    logic signed [QW-1:0] s_start_potential = '0;
    logic signed [QW-1:0] s_start_recovery = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [QW-1:0] m_potential_out;
    logic signed [QW-1:0] m_recovery_out;
    logic                 m_spiked;
    logic [QW-1:0]        m_step_number;
    logic signed [QW-1:0] m_noise_term;
    logic signed [QW-1:0] m_total_current;

    int fail_count;
    int pending;
    int results_checked;
    int spikes_seen;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int beats_sent = 0;
    int settings_used = 0;

    izhikevich_neuron_step_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_noise_sample    (s_noise_sample),
        .s_start_potential (s_start_potential),
        .s_start_recovery  (s_start_recovery),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_potential_out   (m_potential_out),
        .m_recovery_out    (m_recovery_out),
        .m_spiked          (m_spiked),
        .m_step_number     (m_step_number),
        .m_noise_term      (m_noise_term),
        .m_total_current   (m_total_current)
    );

    izh_step_checker chk (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_noise_sample    (s_noise_sample),
        .s_start_potential (s_start_potential),
        .s_start_recovery  (s_start_recovery),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_potential_out   (m_potential_out),
        .m_recovery_out    (m_recovery_out),
        .m_spiked          (m_spiked),
        .m_step_number     (m_step_number),
        .m_noise_term      (m_noise_term),
        .m_total_current   (m_total_current),
        .fail_count        (fail_count),
        .pending           (pending),
        .results_checked   (results_checked),
        .spikes_seen       (spikes_seen)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // leaves cfg_valid high so back-to-back writes keep it up
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [QW-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [QW-1:0] rate, input logic [QW-1:0] sens,
                                 input logic [QW-1:0] c_val, input logic [QW-1:0] jump,
                                 input logic [QW-1:0] dt, input logic [QW-1:0] rdt,
                                 input logic [QW-1:0] drive);
        write_reg(CFG_RATE, rate);
        write_reg(CFG_SENS, sens);
        write_reg(CFG_RST_V, c_val);
        write_reg(CFG_JUMP, jump);
        write_reg(CFG_DT, dt);
        write_reg(CFG_RDT, rdt);
        write_reg(CFG_DRIVE, drive);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // leaves s_valid high; the next beat or quiesce decides what follows
    task automatic send_beat(input logic req, input logic [QW-1:0] noise,
                             input logic [QW-1:0] v_start, input logic [QW-1:0] u_start);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_req_type        <= req;
        s_noise_sample    <= noise;
        s_start_potential <= v_start;
        s_start_recovery  <= u_start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic tick(input logic [QW-1:0] noise);
        send_beat(REQ_TICK, noise, $urandom(), $urandom());
    endtask

    task automatic restart(input logic [QW-1:0] v_start, input logic [QW-1:0] u_start);
        send_beat(REQ_RESTART, $urandom(), v_start, u_start);
    endtask

    // stop sending and wait for every expected result
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    // mostly ticks with modest noise, some restarts and some wild values
    task automatic run_segment(input int count);
        for (int i = 0; i < count; i++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 7) begin
                restart($urandom_range(110 << 16) - (80 << 16),
                        $urandom_range(30 << 16) - (20 << 16));
            end else if (pick < 9) begin
                restart($urandom(), $urandom());
            end else if (pick < 14) begin
                tick($urandom());
            end else begin
                tick($urandom_range(8 << 16) - (4 << 16));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // corner beats under the reset parameters
        tick(32'h0000_0000);
        tick(32'h7FFF_FFFF);
        tick(32'h8000_0000);
        restart(32'h7FFF_FFFF, 32'h8000_0000);
        tick(32'h0000_0000);
        restart(32'h8000_0000, 32'h7FFF_FFFF);
        tick(32'hFFFF_FFFF);
        restart(29 << 16, 32'h0000_0000);
        tick(32'h0010_0000);
        tick(32'h0000_0000);

        // dt zero and sqrt(dt) one: the potential moves by the noise alone,
        // so the threshold can be hit exactly and just missed
        quiesce();
        apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h0000_0000, 32'h0001_0000, 32'h8000_0000);
        restart(32'h0000_0000, 32'h0000_0000);
        tick(Q_30);
        restart(32'h0000_0000, 32'h0000_0000);
        tick(Q_30 - 1);
        tick(32'h8000_0000);
        tick(32'h7FFF_FFFF);

        // three flow-control regimes, three register settings in each
        for (int regime = 0; regime < 3; regime++) begin
            src_idle_pct  = (regime == 0) ? 31 : (regime == 1) ? 49 : 0;
            sink_idle_pct = (regime == 0) ? 49 : (regime == 1) ? 31 : 0;
            for (int seg = 0; seg < 3; seg++) begin
                quiesce();
                if (seg == 0) begin
                    // plausible neuron parameters
                    apply_setting(655 + $urandom_range(6553), 6554 + $urandom_range(13107),
                                  -(50 << 16) - $urandom_range(20 << 16),
                                  $urandom_range(8 << 16), 3277 + $urandom_range(62259),
                                  $urandom_range(65536), $urandom_range(20 << 16));
                end else if (seg == 1) begin
                    apply_setting($urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom(), $urandom());
                    write_reg(CFG_UNUSED, $urandom());
                    @(negedge aclk);
                    cfg_valid <= 1'b0;
                end else if (regime == 1) begin
                    apply_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
                end else begin
                    apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
                end
                run_segment(45);
            end
        end

        quiesce();
        repeat (25) @(posedge aclk);
        $display("run covered %0d input beats over %0d register settings in three flow regimes",
                 beats_sent, settings_used);
        $display("%0d result beats compared, %0d of them with a spike",
                 results_checked, spikes_seen);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
